@@ rtl/core/brrm_pkg.sv @@
`default_nettype none

package brrm_pkg;

  localparam int NUM_VALUES = 32;
  localparam int IDX_W = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;
  localparam int CNT_W = $clog2(NUM_VALUES + 1);
  localparam int VAL_W = 64;
  localparam int CMD_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_LOAD   = 3'd1,
    CMD_STAGE  = 3'd2,
    CMD_RANGE  = 3'd3,
    CMD_REPORT = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_REMAP = 3'b010,
    ST_MIN   = 3'b100
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/batch_range_remap_min.sv @@
`default_nettype none

// Holds up to NUM_VALUES 64-bit values in a synchronous memory with one read port and one
// write port, and remaps them through range entries or reports their minimum. Clear, load
// and stage commands are handled in the idle state. A range entry or a report on a non-empty
// batch walks the held values one per cycle through the read port, and a remapped value is
// written back in the cycle after its read. in_ready stays low after such a transfer until
// the walk is done and the block is back in idle, where the next transfer can be accepted.
// A report produces one result transfer; the result waits in an output register
// while loads and other commands continue, and only a second report waits for it.
// Value storage has no reset; the moved marks and the count are cleared at reset.
module batch_range_remap_min (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [brrm_pkg::CMD_W-1:0]    in_command,
  input  wire logic [brrm_pkg::VAL_W-1:0]    in_value,
  input  wire logic [brrm_pkg::VAL_W-1:0]    in_dest_start,
  input  wire logic [brrm_pkg::VAL_W-1:0]    in_src_start,
  input  wire logic [brrm_pkg::VAL_W-1:0]    in_range_length,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [brrm_pkg::VAL_W-1:0]         out_min_value,
  output logic                               out_empty_res
);

  localparam int VW = brrm_pkg::VAL_W;
  localparam int IW = brrm_pkg::IDX_W;
  localparam int CW = brrm_pkg::CNT_W;
  localparam int NV = brrm_pkg::NUM_VALUES;

  logic [VW-1:0] mem [NV];
  logic [VW-1:0] rdata_r;

  brrm_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [NV-1:0] marks_r, marks_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic          pend_r, pend_nxt;
  logic [IW-1:0] pend_idx_r, pend_idx_nxt;
  logic [VW-1:0] dst_r, dst_nxt, src_r, src_nxt, len_r, len_nxt;
  logic [VW-1:0] best_r, best_nxt;
  logic          first_r, first_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [VW-1:0] out_min_r, out_min_nxt;
  logic          out_empty_r, out_empty_nxt;

  logic          re, we;
  logic [IW-1:0] raddr, waddr;
  logic [VW-1:0] wdata;
  logic [VW:0]   diff;
  logic          hit;
  logic          accept;
  logic          issue_more;

  assign in_ready = (state_r == brrm_pkg::ST_IDLE) &&
                    (!out_valid_r || (in_command != brrm_pkg::CMD_REPORT));
  assign accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_min_value = out_min_r;
  assign out_empty_res = out_empty_r;

  assign diff = {1'b0, rdata_r} - {1'b0, src_r};
  assign hit = !diff[VW] && (diff[VW-1:0] < len_r) && !marks_r[pend_idx_r];
  assign issue_more = (issue_r < count_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    marks_nxt = marks_r;
    issue_nxt = issue_r;
    pend_nxt = 1'b0;
    pend_idx_nxt = pend_idx_r;
    dst_nxt = dst_r;
    src_nxt = src_r;
    len_nxt = len_r;
    best_nxt = best_r;
    first_nxt = first_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_min_nxt = out_min_r;
    out_empty_nxt = out_empty_r;
    re = 1'b0;
    raddr = issue_r[IW-1:0];
    we = 1'b0;
    waddr = count_r[IW-1:0];
    wdata = in_value;

    case (state_r)
      brrm_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_command)
            brrm_pkg::CMD_CLEAR: begin
              count_nxt = '0;
              marks_nxt = '0;
            end
            brrm_pkg::CMD_LOAD: begin
              if (count_r < CW'(NV)) begin
                we = 1'b1;
                marks_nxt[count_r[IW-1:0]] = 1'b0;
                count_nxt = count_r + 1'b1;
              end
            end
            brrm_pkg::CMD_STAGE: begin
              marks_nxt = '0;
            end
            brrm_pkg::CMD_RANGE: begin
              dst_nxt = in_dest_start;
              src_nxt = in_src_start;
              len_nxt = in_range_length;
              issue_nxt = '0;
              if (count_r != '0) begin
                state_nxt = brrm_pkg::ST_REMAP;
              end
            end
            brrm_pkg::CMD_REPORT: begin
              issue_nxt = '0;
              first_nxt = 1'b1;
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_min_nxt = '0;
                out_empty_nxt = 1'b1;
              end else begin
                state_nxt = brrm_pkg::ST_MIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      brrm_pkg::ST_REMAP: begin
        if (issue_more) begin
          re = 1'b1;
          pend_nxt = 1'b1;
          pend_idx_nxt = issue_r[IW-1:0];
          issue_nxt = issue_r + 1'b1;
        end
        if (pend_r && hit) begin
          we = 1'b1;
          waddr = pend_idx_r;
          wdata = dst_r + diff[VW-1:0];
          marks_nxt[pend_idx_r] = 1'b1;
        end
        if (!issue_more && !pend_r) begin
          state_nxt = brrm_pkg::ST_IDLE;
        end
      end
      brrm_pkg::ST_MIN: begin
        if (issue_more) begin
          re = 1'b1;
          pend_nxt = 1'b1;
          pend_idx_nxt = issue_r[IW-1:0];
          issue_nxt = issue_r + 1'b1;
        end
        if (pend_r) begin
          first_nxt = 1'b0;
          if (first_r || (rdata_r < best_r)) begin
            best_nxt = rdata_r;
          end
        end
        if (!issue_more && !pend_r) begin
          out_valid_nxt = 1'b1;
          out_min_nxt = best_r;
          out_empty_nxt = 1'b0;
          state_nxt = brrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = brrm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brrm_pkg::ST_IDLE;
      count_r <= '0;
      marks_r <= '0;
      issue_r <= '0;
      pend_r <= 1'b0;
      first_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      marks_r <= marks_nxt;
      issue_r <= issue_nxt;
      pend_r <= pend_nxt;
      first_r <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    dst_r <= dst_nxt;
    src_r <= src_nxt;
    len_r <= len_nxt;
    best_r <= best_nxt;
    out_min_r <= out_min_nxt;
    out_empty_r <= out_empty_nxt;
  end

endmodule

`default_nettype wire

@@ tb/sv/remap_min_checker.sv @@
`timescale 1ns / 100ps

module remap_min_checker
  import brrm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_ready,
  input  wire logic [CMD_W-1:0] in_command,
  input  wire logic [VAL_W-1:0] in_value,
  input  wire logic [VAL_W-1:0] in_dest_start,
  input  wire logic [VAL_W-1:0] in_src_start,
  input  wire logic [VAL_W-1:0] in_range_length,
  input  wire logic             out_valid,
  input  wire logic             out_ready,
  input  wire logic [VAL_W-1:0] out_min_value,
  input  wire logic             out_empty_res,
  output int                    error_count,
  output int                    outstanding
);

  typedef struct packed {
    logic [VAL_W-1:0] min_value;
    logic             empty;
  } min_report_t;

  logic [VAL_W-1:0] batch_vals [NUM_VALUES];
  bit               moved      [NUM_VALUES];
  int unsigned      batch_len;
  min_report_t      pending_reports [$];

  initial begin
    error_count = 0;
    outstanding = 0;
    batch_len = 0;
    foreach (batch_vals[k]) begin
      batch_vals[k] = '0;
      moved[k] = 1'b0;
    end
  end

  task automatic count_error(input string what, input min_report_t want, input min_report_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s: expected min %h empty %b, got min %h empty %b", $realtime, what,
               want.min_value, want.empty, got.min_value, got.empty);
    end
  endtask

  task automatic remap_batch(input logic [VAL_W-1:0] dst, input logic [VAL_W-1:0] src,
                             input logic [VAL_W-1:0] len);
    logic [VAL_W-1:0] offset;
    for (int k = 0; k < batch_len; k++) begin
      if (!moved[k] && batch_vals[k] >= src) begin
        offset = batch_vals[k] - src;
        if (offset < len) begin
          batch_vals[k] = dst + offset;
          moved[k] = 1'b1;
        end
      end
    end
  endtask

  function automatic min_report_t batch_minimum();
    min_report_t res;
    res.min_value = '0;
    res.empty = (batch_len == 0);
    if (batch_len != 0) begin
      res.min_value = batch_vals[0];
      for (int k = 1; k < batch_len; k++) begin
        if (batch_vals[k] < res.min_value) res.min_value = batch_vals[k];
      end
    end
    return res;
  endfunction

  task automatic take_command();
    case (in_command)
      CMD_CLEAR: begin
        batch_len = 0;
        foreach (moved[k]) moved[k] = 1'b0;
      end
      CMD_LOAD: begin
        if (batch_len < NUM_VALUES) begin
          batch_vals[batch_len] = in_value;
          moved[batch_len] = 1'b0;
          batch_len++;
        end
      end
      CMD_STAGE: begin
        foreach (moved[k]) moved[k] = 1'b0;
      end
      CMD_RANGE: remap_batch(in_dest_start, in_src_start, in_range_length);
      CMD_REPORT: pending_reports.push_back(batch_minimum());
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    min_report_t got;
    min_report_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.min_value = out_min_value;
        got.empty = out_empty_res;
        if (pending_reports.size() == 0) begin
          want = '0;
          count_error("result transfer with no report pending", want, got);
        end else begin
          want = pending_reports.pop_front();
          if (got.min_value !== want.min_value || got.empty !== want.empty) begin
            count_error("report mismatch", want, got);
          end
        end
      end
      if (in_valid && in_ready) take_command();
    end
    outstanding <= pending_reports.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import brrm_pkg::*;

  localparam logic [VAL_W-1:0] ALL_ONES = '1;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [CMD_W-1:0] in_command;
  logic [VAL_W-1:0] in_value;
  logic [VAL_W-1:0] in_dest_start;
  logic [VAL_W-1:0] in_src_start;
  logic [VAL_W-1:0] in_range_length;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [VAL_W-1:0] out_min_value;
  logic             out_empty_res;

  int error_count;
  int outstanding;
  int send_gap_pct = 0;
  int sink_stall_pct = 0;
  int items_sent = 0;

  batch_range_remap_min i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_value        (in_value),
    .in_dest_start   (in_dest_start),
    .in_src_start    (in_src_start),
    .in_range_length (in_range_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_min_value   (out_min_value),
    .out_empty_res   (out_empty_res)
  );

  remap_min_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_value        (in_value),
    .in_dest_start   (in_dest_start),
    .in_src_start    (in_src_start),
    .in_range_length (in_range_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_min_value   (out_min_value),
    .out_empty_res   (out_empty_res),
    .error_count     (error_count),
    .outstanding     (outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin
    #8_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [VAL_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VAL_W-1:0] near(input logic [VAL_W-1:0] base);
    return base + VAL_W'($urandom_range(1023));
  endfunction

  function automatic logic [VAL_W-1:0] pick_len();
    case ($urandom_range(9))
      0: return '0;
      1: return ALL_ONES;
      2: return rand64();
      default: return VAL_W'($urandom_range(1, 600));
    endcase
  endfunction

  // Valid is only lowered on an idle cycle, so back-to-back transfers keep it high.
  task automatic send_item(input logic [CMD_W-1:0] command, input logic [VAL_W-1:0] value,
                           input logic [VAL_W-1:0] dest, input logic [VAL_W-1:0] src,
                           input logic [VAL_W-1:0] len);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= command;
    in_value <= value;
    in_dest_start <= dest;
    in_src_start <= src;
    in_range_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (command <= CMD_REPORT) items_sent++;
  endtask

  task automatic send_plain(input logic [CMD_W-1:0] command);
    send_item(command, rand64(), rand64(), rand64(), rand64());
  endtask

  task automatic send_load(input logic [VAL_W-1:0] value);
    send_item(CMD_LOAD, value, rand64(), rand64(), rand64());
  endtask

  task automatic send_range(input logic [VAL_W-1:0] dest, input logic [VAL_W-1:0] src,
                            input logic [VAL_W-1:0] len);
    send_item(CMD_RANGE, rand64(), dest, src, len);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Values and range source starts stay in one window so that entries keep hitting the batch.
  task automatic run_batch();
    logic [VAL_W-1:0] base;
    int fill;
    base = ($urandom_range(3) == 0) ? ALL_ONES - VAL_W'($urandom_range(600)) : rand64();
    fill = ($urandom_range(7) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 12);
    send_plain(CMD_CLEAR);
    repeat (fill) send_load(near(base));
    repeat ($urandom_range(1, 4)) begin
      send_plain(CMD_STAGE);
      repeat ($urandom_range(0, 5)) begin
        send_range(($urandom_range(4) == 0) ? rand64() : near(base), near(base), pick_len());
      end
      if ($urandom_range(2) == 0) send_plain(CMD_REPORT);
    end
    send_plain(CMD_REPORT);
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 6)) begin
      send_item(CMD_W'($urandom_range(7)), rand64(), rand64(), rand64(), rand64());
    end
  endtask

  initial begin
    int phase_end;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_CLEAR;
    in_value <= '0;
    in_dest_start <= '0;
    in_src_start <= '0;
    in_range_length <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_plain(CMD_REPORT);
    send_load('0);
    send_load(ALL_ONES);
    send_load(64'h8000_0000_0000_0000);
    send_load(64'd5);
    send_plain(CMD_REPORT);
    send_plain(CMD_STAGE);
    send_range(64'd100, 64'd0, 64'd0);
    send_range(64'd10, 64'd0, 64'd1);
    send_range(64'd0, 64'd10, 64'd1);
    send_range(64'd1, 64'hFFFF_FFFF_FFFF_FFF0, ALL_ONES);
    send_range(ALL_ONES, 64'd5, 64'd1);
    send_range(64'hFFFF_FFFF_FFFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFE, 64'h1000);
    send_plain(CMD_REPORT);
    send_plain(CMD_STAGE);
    send_range('0, '0, ALL_ONES);
    send_plain(3'd5);
    send_plain(3'd6);
    send_plain(3'd7);
    send_plain(CMD_REPORT);
    send_plain(CMD_CLEAR);
    send_plain(CMD_REPORT);
    drain_reports();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          send_gap_pct = 69;
          sink_stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          sink_stall_pct = 69;
        end
        default: begin
          send_gap_pct = 16;
          sink_stall_pct = 16;
        end
      endcase
      phase_end = items_sent + 285;
      while (items_sent < phase_end) begin
        if ($urandom_range(6) == 0) run_noise();
        else run_batch();
      end
      drain_reports();
    end

    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/brrm_pkg.sv
rtl/core/batch_range_remap_min.sv
tb/sv/remap_min_checker.sv
tb/sv/testbench.sv
